// ===== hw/rtl/okl_pkg.sv =====
// Package for the ordered keyed list: opcode and status codes, and the
// transaction token that walks the cell chain. No dependencies.
package okl_pkg;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_PREPEND = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_DELETE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  // Request token handed from cell to cell
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    carry_key;
    logic [HANDLE_W-1:0] carry_handle;
    logic [HANDLE_W-1:0] found_handle;
    logic                full;
    logic                hit;
  } tok_t;

endpackage

// ===== hw/rtl/okl_req_if.sv =====
// Request channel interface for the ordered keyed list.
// Depends on nothing; field widths match okl_pkg.
interface okl_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] key;
  logic [31:0]        record_handle;

  modport source (output valid, output opcode, output key, output record_handle,
                  input ready);
  modport sink (input valid, input opcode, input key, input record_handle,
                output ready);
endinterface

// ===== hw/rtl/okl_rsp_if.sv =====
// Result channel interface for the ordered keyed list.
// Depends on nothing; field widths match okl_pkg.
interface okl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_handle;
  logic [3:0]  found_position;
  logic [4:0]  entry_count;

  modport source (output valid, output status, output found_handle,
                  output found_position, output entry_count, input ready);
  modport sink (input valid, input status, input found_handle,
                input found_position, input entry_count, output ready);
endinterface

// ===== hw/rtl/ordered_keyed_list_core.sv =====
// Ordered keyed list: a chain of okl_cell entries with a result register.
// Depends on okl_pkg, okl_req_if, okl_rsp_if, okl_cell.
//
// Usage: requests arrive on the req channel (opcode, key, record_handle),
// one result per request leaves on the rsp channel (status, found_handle,
// found_position, entry_count). A transaction moves on valid && ready.
// Append stores at the tail, prepend at the head, search returns the
// handle and position of the first key match, delete removes it and the
// cells behind it move up one place. An insert into a full list returns
// status full and leaves the list as it was.
// Each accepted request travels down the cell chain, one cell per cycle
// while the chain is not held; its result then lands in the output register.
// One request is in the chain at a time, so a new request is not taken until
// the last one has left the chain. req.ready is high whenever the chain
// is empty, also while a finished result waits in the output register.
// If the receiver stalls while a token reaches the end of the chain, the
// whole chain holds until the output register frees.
// Reset (rst, synchronous) empties the list, clears the output valid and
// holds req.ready low.
module ordered_keyed_list_core #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  okl_req_if.sink   req,
  okl_rsp_if.source rsp
);
  import okl_pkg::*;

  localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

  tok_t                tok      [LIST_DEPTH+1];
  logic [IDX_W-1:0]    pos      [LIST_DEPTH+1];
  logic [KEY_W-1:0]    ent_key  [LIST_DEPTH];
  logic [HANDLE_W-1:0] ent_hdl  [LIST_DEPTH];
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                busy;
  logic                accept;
  logic                adv;
  logic                done;
  logic                is_insert;
  op_t                 req_op;
  tok_t                last;
  logic [IDX_W+3:0]    pos_ext;
  logic [CNT_W+4:0]    cnt_ext;

  assign req_op    = op_t'(req.opcode);
  assign is_insert = (req_op == OP_APPEND) || (req_op == OP_PREPEND);
  assign req.ready = !busy && !rst;
  assign accept    = req.valid && req.ready;

  always_comb begin
    tok[0]              = '0;
    tok[0].valid        = accept;
    tok[0].op           = req_op;
    tok[0].key          = req.key;
    tok[0].carry_key    = req.key;
    tok[0].carry_handle = req.record_handle;
    tok[0].full         = is_insert && (count == CNT_W'(LIST_DEPTH));
    pos[0]              = '0;
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0]    nk;
    logic [HANDLE_W-1:0] nh;
    if (i == LIST_DEPTH - 1) begin : g_end
      assign nk = ent_key[i];
      assign nh = ent_hdl[i];
    end else begin : g_mid
      assign nk = ent_key[i+1];
      assign nh = ent_hdl[i+1];
    end
    okl_cell #(
      .CELL_INDEX(i),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .tok_in    (tok[i]),
      .pos_in    (pos[i]),
      .occ       (CNT_W'(i) < count),
      .tail      (CNT_W'(i) == count),
      .nxt_key   (nk),
      .nxt_handle(nh),
      .tok_out   (tok[i+1]),
      .pos_out   (pos[i+1]),
      .ent_key   (ent_key[i]),
      .ent_handle(ent_hdl[i])
    );
  end

  assign last = tok[LIST_DEPTH];
  assign adv  = !(last.valid && rsp.valid && !rsp.ready);
  assign done = last.valid && adv;

  always_comb begin
    count_next = count;
    if (!last.full) begin
      if (last.op == OP_APPEND || last.op == OP_PREPEND) begin
        count_next = count + CNT_W'(1);
      end else if (last.op == OP_DELETE && last.hit) begin
        count_next = count - CNT_W'(1);
      end
    end
  end

  assign pos_ext = {4'b0, pos[LIST_DEPTH]};
  assign cnt_ext = {5'b0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (last.full) begin
        rsp.status <= ST_FULL;
      end else if ((last.op == OP_SEARCH || last.op == OP_DELETE) && !last.hit) begin
        rsp.status <= ST_MISS;
      end else begin
        rsp.status <= ST_OK;
      end
      rsp.found_handle   <= (last.op == OP_SEARCH && last.hit) ? last.found_handle : '0;
      rsp.found_position <= last.hit ? pos_ext[3:0] : 4'd0;
      rsp.entry_count    <= cnt_ext[4:0];
    end
  end

endmodule

// ===== hw/rtl/okl_cell.sv =====
// One list cell: holds one entry and processes the passing request token.
// Depends on okl_pkg.
module okl_cell #(
  parameter int unsigned CELL_INDEX = 0,
  parameter int unsigned IDX_W      = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  okl_pkg::tok_t                tok_in,
  input  logic [IDX_W-1:0]             pos_in,
  input  logic                         occ,
  input  logic                         tail,
  input  logic [okl_pkg::KEY_W-1:0]    nxt_key,
  input  logic [okl_pkg::HANDLE_W-1:0] nxt_handle,
  output okl_pkg::tok_t                tok_out,
  output logic [IDX_W-1:0]             pos_out,
  output logic [okl_pkg::KEY_W-1:0]    ent_key,
  output logic [okl_pkg::HANDLE_W-1:0] ent_handle
);
  import okl_pkg::*;

  tok_t                tok_next;
  logic [IDX_W-1:0]    pos_next;
  logic [KEY_W-1:0]    ent_key_next;
  logic [HANDLE_W-1:0] ent_handle_next;
  logic                match;

  assign match = occ && !tok_in.hit && (ent_key == tok_in.key);

  always_comb begin
    tok_next        = tok_in;
    pos_next        = pos_in;
    ent_key_next    = ent_key;
    ent_handle_next = ent_handle;
    if (tok_in.valid && !tok_in.full) begin
      unique case (tok_in.op)
        OP_APPEND: begin
          if (tail) begin
            ent_key_next    = tok_in.carry_key;
            ent_handle_next = tok_in.carry_handle;
          end
        end
        OP_PREPEND: begin
          // take the carried entry, pass the old one toward the tail
          if (occ || tail) begin
            ent_key_next          = tok_in.carry_key;
            ent_handle_next       = tok_in.carry_handle;
            tok_next.carry_key    = ent_key;
            tok_next.carry_handle = ent_handle;
          end
        end
        OP_SEARCH: begin
          if (match) begin
            tok_next.hit          = 1'b1;
            tok_next.found_handle = ent_handle;
            pos_next              = IDX_W'(CELL_INDEX);
          end
        end
        OP_DELETE: begin
          if (match) begin
            tok_next.hit = 1'b1;
            pos_next     = IDX_W'(CELL_INDEX);
          end
          // from the match on, pull the neighbor in; it is not yet visited
          if (occ && (match || tok_in.hit)) begin
            ent_key_next    = nxt_key;
            ent_handle_next = nxt_handle;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      pos_out <= '0;
    end else if (adv) begin
      tok_out <= tok_next;
      pos_out <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_key    <= ent_key_next;
      ent_handle <= ent_handle_next;
    end
  end

endmodule

// ===== hw/rtl/okl_checker.sv =====
// Port-level checks for ordered_keyed_list_core, attached with bind.
// Depends on okl_pkg.
module okl_checker #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] found_handle,
  input logic [3:0]  found_position,
  input logic [4:0]  entry_count
);
  import okl_pkg::*;

  localparam logic [4:0] FULL_COUNT = 5'(LIST_DEPTH);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == FULL_COUNT)
    else $error("full status with list not full");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> found_handle == '0 && found_position == '0)
    else $error("found fields set on a miss or reject");

endmodule

bind ordered_keyed_list_core okl_checker #(.LIST_DEPTH(LIST_DEPTH)) u_okl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (req.valid),
  .in_ready      (req.ready),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .status        (rsp.status),
  .found_handle  (rsp.found_handle),
  .found_position(rsp.found_position),
  .entry_count   (rsp.entry_count)
);
